// ===== rtl/core/cfmu_pkg.sv =====
// ----------------------------------------------------------------------------
// cfmu_pkg
// Shared types, constants and saturation helpers of the contact unit.
// ----------------------------------------------------------------------------
package cfmu_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int MAX_VERTICES = 1024;
	localparam int VTX_W        = 10;
	localparam int MUL_A_W      = 48;
	localparam int MUL_B_W      = 34;
	localparam int MUL_P_W      = 82;
	localparam int MUL_CNT_W    = 6;
	localparam int SQ_W         = 64;
	localparam int ROOT_W       = 33;
	localparam int FMAX_W       = 47;
	localparam int QUO_W        = 32;
	localparam int IN_W         = 248;
	localparam int OUT_W        = 288;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWNER    = 3'd0,
		REG_CONTACTX = 3'd1,
		REG_CONTACTY = 3'd2,
		REG_CONTACTZ = 3'd3,
		REG_NORMALX  = 3'd4,
		REG_NORMALY  = 3'd5,
		REG_NORMALZ  = 3'd6,
		REG_FRICTION = 3'd7
	} reg_idx_t;

	localparam logic KIND_GRAD   = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// sequencer step numbers, one product per step
	localparam logic [4:0] STEP_SEP   = 5'd0;
	localparam logic [4:0] STEP_VN    = 5'd3;
	localparam logic [4:0] STEP_TAN   = 5'd6;
	localparam logic [4:0] STEP_RHOC  = 5'd9;
	localparam logic [4:0] STEP_RT    = 5'd10;
	localparam logic [4:0] STEP_GRAD  = 5'd13;
	localparam logic [4:0] STEP_SQ    = 5'd16;
	localparam logic [4:0] STEP_FMU   = 5'd19;
	localparam logic [4:0] STEP_SCALE = 5'd20;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} hs_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647)
			return 32'h7fffffff;
		else if (x < -66'sd2147483648)
			return 32'h80000000;
		return 32'(x);
	endfunction

	function automatic logic [30:0] sat31u(input logic signed [65:0] x);
		if (x > 66'sd2147483647)
			return 31'h7fffffff;
		else if (x < 66'sd0)
			return 31'd0;
		return 31'(x);
	endfunction

endpackage

// ===== rtl/core/cfmu_mul.sv =====
// ----------------------------------------------------------------------------
// cfmu_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cfmu_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [cfmu_pkg::MUL_A_W-1:0]   a,
	input  logic signed [cfmu_pkg::MUL_B_W-1:0]   b,
	output logic                                  done,
	output logic signed [cfmu_pkg::MUL_P_W-1:0]   p
);

	logic signed [cfmu_pkg::MUL_A_W:0]   hi_q;
	logic        [cfmu_pkg::MUL_B_W-1:0] lo_q;
	logic signed [cfmu_pkg::MUL_A_W-1:0] a_q;
	logic        [cfmu_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic signed [cfmu_pkg::MUL_A_W+1:0] addend;
	logic signed [cfmu_pkg::MUL_A_W+1:0] sum;
	logic                                last;
	logic [cfmu_pkg::MUL_A_W+cfmu_pkg::MUL_B_W:0] prod;

	assign last = (cnt_q == cfmu_pkg::MUL_CNT_W'(cfmu_pkg::MUL_B_W - 1));

	always_comb begin
		if (!lo_q[0])
			addend = '0;
		else if (last)
			addend = -(cfmu_pkg::MUL_A_W+2)'(a_q);
		else
			addend = (cfmu_pkg::MUL_A_W+2)'(a_q);
		sum = (cfmu_pkg::MUL_A_W+2)'(hi_q) + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
			a_q  <= a;
		end else if (busy_q) begin
			hi_q <= sum[cfmu_pkg::MUL_A_W+1:1];
			lo_q <= {sum[0], lo_q[cfmu_pkg::MUL_B_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};
	assign p    = prod[cfmu_pkg::MUL_P_W-1:0];
	assign done = done_q;

endmodule

// ===== rtl/core/cfmu_sqrt.sv =====
// ----------------------------------------------------------------------------
// cfmu_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module cfmu_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfmu_pkg::hs_t                     ctl_in,
	output cfmu_pkg::hs_t                     ctl_out,
	input  logic [cfmu_pkg::SQ_W-1:0]         x,
	output logic [cfmu_pkg::ROOT_W-1:0]       root
);

	logic [cfmu_pkg::SQ_W-1:0] x_q;
	logic [cfmu_pkg::SQ_W-1:0] r_q;
	logic [cfmu_pkg::SQ_W-1:0] bit_q;
	logic [cfmu_pkg::SQ_W-1:0] trial;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			x_q   <= x;
			r_q   <= '0;
			bit_q <= cfmu_pkg::SQ_W'(1) << (cfmu_pkg::SQ_W - 2);
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign ctl_out.start = 1'b0;
	assign ctl_out.done  = done_q;
	assign root          = r_q[cfmu_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/core/cfmu_div.sv =====
// ----------------------------------------------------------------------------
// cfmu_div
// Restoring divider, one quotient bit per cycle; quotient known below 2^32.
// ----------------------------------------------------------------------------
module cfmu_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfmu_pkg::hs_t                     ctl_in,
	output cfmu_pkg::hs_t                     ctl_out,
	input  logic [cfmu_pkg::SQ_W-1:0]         dividend,
	input  logic [cfmu_pkg::ROOT_W-1:0]       divisor,
	output logic [cfmu_pkg::QUO_W-1:0]        quotient
);

	logic [cfmu_pkg::ROOT_W-1:0] rem_q;
	logic [cfmu_pkg::QUO_W-1:0]  dq_q;
	logic [cfmu_pkg::ROOT_W-1:0] dv_q;
	logic [cfmu_pkg::ROOT_W:0]   t;
	logic                        ge;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;

	assign t  = {rem_q, dq_q[cfmu_pkg::QUO_W-1]};
	assign ge = (t >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= cfmu_pkg::ROOT_W'(dividend[cfmu_pkg::SQ_W-1:cfmu_pkg::QUO_W]);
			dq_q  <= dividend[cfmu_pkg::QUO_W-1:0];
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? cfmu_pkg::ROOT_W'(t - {1'b0, dv_q}) : t[cfmu_pkg::ROOT_W-1:0];
			dq_q  <= {dq_q[cfmu_pkg::QUO_W-2:0], ge};
		end
	end

	assign ctl_out.start = 1'b0;
	assign ctl_out.done  = done_q;
	assign quotient      = dq_q;

endmodule

// ===== rtl/core/contact_friction_multiplier_unit.sv =====
// ----------------------------------------------------------------------------
// contact_friction_multiplier_unit
// Contact constraint with Coulomb friction, Q16.16, sequenced over a shared
// bit-serial multiplier, a serial square root and a serial divider.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata (query word), s_tuser (kind)
// m_      | out | m_tvalid/m_tready  | m_tdata (result word)
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Products run in the shared bit-serial multiplier, roots and divides in their serial units.
// Kind 0 ends early for another vertex or an inactive contact; kind 1 runs
// longer when the cone scaling runs; an absent vertex skips the arithmetic.
// One word in flight; the next is taken while a result waits in m_tdata.
// Reset clears the multipliers and loads the register defaults.
// ----------------------------------------------------------------------------
module contact_friction_multiplier_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vertex_index, vertex_present, pos_x/y/z, vel_x/y/z, penalty, time_step
	input  logic [cfmu_pkg::IN_W-1:0]           s_tdata,
	// kind
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// grad_x/y/z, diag_add, is_active, normal_mult, tangent_mult_x/y/z,
	// penetration
	output logic [cfmu_pkg::OUT_W-1:0]          m_tdata,
	input  logic                                cfg_we,
	input  logic [cfmu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cfmu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	cfmu_pkg::state_t state_q;
	logic [4:0]  pc_q;
	logic [1:0]  idx;
	logic        kind_q;
	logic [9:0]  vidx_q;
	logic        pres_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic [30:0] rho_q;
	logic [11:0] dt_q;

	logic [9:0]         owner_q;
	logic signed [31:0] cp_q [3];
	logic signed [17:0] n_q [3];
	logic [30:0]        mu_q;

	logic signed [31:0] ln_s;
	logic [30:0]        ln_q;
	logic signed [31:0] tm_q [3];

	logic signed [53:0] acc_q;
	logic signed [53:0] acc_nx;
	logic signed [31:0] c_q;
	logic signed [31:0] vn_q;
	logic signed [31:0] t_q [3];
	logic signed [31:0] psi_q;
	logic signed [31:0] grad_q [3];
	logic        diag_en_q;
	logic        active_q;
	logic [30:0] pen_q;
	logic [63:0] sq_q;
	logic [cfmu_pkg::FMAX_W-1:0] fmax_q;
	logic        pres_in;
	logic        take;
	logic [31:0] mag;
	logic [28:0] rho_t;
	logic [32:0] diag_sum;
	logic [30:0] diag;

	logic                                 mul_go_q;
	logic                                 mul_done;
	logic signed [cfmu_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [cfmu_pkg::MUL_B_W-1:0]  mul_b;
	logic signed [cfmu_pkg::MUL_P_W-1:0]  mul_p;
	logic signed [65:0]                   ps;
	logic signed [31:0]                   c_nx;

	cfmu_pkg::hs_t sqrt_in, sqrt_out, div_in, div_out;
	logic [cfmu_pkg::ROOT_W-1:0] root;
	logic [cfmu_pkg::QUO_W-1:0]  quo;
	logic                        sqrt_go_q;
	logic                        div_go_q;
	logic                        out_v_q;
	logic [cfmu_pkg::OUT_W-1:0]  out_q;

	assign s_tready = (state_q == cfmu_pkg::ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign pres_in  = s_tdata[10] && ({1'b0, owner_q} < 11'(cfmu_pkg::MAX_VERTICES));
	assign rho_t    = rho_q[30:2];
	assign ln_s     = 32'(ln_q);
	assign ps       = 66'(mul_p >>> cfmu_pkg::FRAC_BITS);
	assign acc_nx   = acc_q + 54'(mul_p);
	assign c_nx     = cfmu_pkg::sat32(66'(acc_nx >>> cfmu_pkg::FRAC_BITS));
	assign diag_sum = 33'(rho_q) + 33'(rho_t) + 33'(rho_t) + 33'(rho_t);
	assign diag     = diag_sum[32:31] != 2'b00 ? 31'h7fffffff : diag_sum[30:0];

	always_comb begin
		case (pc_q) inside
			[cfmu_pkg::STEP_SEP:cfmu_pkg::STEP_SEP+5'd2]:     idx = 2'(pc_q - cfmu_pkg::STEP_SEP);
			[cfmu_pkg::STEP_VN:cfmu_pkg::STEP_VN+5'd2]:       idx = 2'(pc_q - cfmu_pkg::STEP_VN);
			[cfmu_pkg::STEP_TAN:cfmu_pkg::STEP_TAN+5'd2]:     idx = 2'(pc_q - cfmu_pkg::STEP_TAN);
			[cfmu_pkg::STEP_RT:cfmu_pkg::STEP_RT+5'd2]:       idx = 2'(pc_q - cfmu_pkg::STEP_RT);
			[cfmu_pkg::STEP_GRAD:cfmu_pkg::STEP_GRAD+5'd2]:   idx = 2'(pc_q - cfmu_pkg::STEP_GRAD);
			[cfmu_pkg::STEP_SQ:cfmu_pkg::STEP_SQ+5'd2]:       idx = 2'(pc_q - cfmu_pkg::STEP_SQ);
			[cfmu_pkg::STEP_SCALE:cfmu_pkg::STEP_SCALE+5'd2]: idx = 2'(pc_q - cfmu_pkg::STEP_SCALE);
			default:                                          idx = 2'd0;
		endcase
	end

	always_comb begin
		if (tm_q[idx] < 0)
			mag = 32'(-tm_q[idx]);
		else
			mag = 32'(tm_q[idx]);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (pc_q) inside
			[cfmu_pkg::STEP_SEP:cfmu_pkg::STEP_SEP+5'd2]: begin
				mul_a = 48'(n_q[idx]);
				mul_b = 34'(pos_q[idx]) - 34'(cp_q[idx]);
			end
			[cfmu_pkg::STEP_VN:cfmu_pkg::STEP_VN+5'd2]: begin
				mul_a = 48'(vel_q[idx]);
				mul_b = 34'(n_q[idx]);
			end
			[cfmu_pkg::STEP_TAN:cfmu_pkg::STEP_TAN+5'd2]: begin
				mul_a = 48'(vn_q);
				mul_b = 34'(n_q[idx]);
			end
			cfmu_pkg::STEP_RHOC: begin
				mul_a = 48'(c_q);
				mul_b = 34'(rho_q);
			end
			[cfmu_pkg::STEP_RT:cfmu_pkg::STEP_RT+5'd2]: begin
				mul_a = 48'(t_q[idx]);
				mul_b = 34'(rho_t);
			end
			[cfmu_pkg::STEP_GRAD:cfmu_pkg::STEP_GRAD+5'd2]: begin
				if (kind_q == cfmu_pkg::KIND_GRAD) begin
					mul_a = 48'(psi_q);
					mul_b = 34'(n_q[idx]);
				end else begin
					mul_a = 48'(t_q[idx]);
					mul_b = 34'(dt_q);
				end
			end
			[cfmu_pkg::STEP_SQ:cfmu_pkg::STEP_SQ+5'd2]: begin
				mul_a = 48'(tm_q[idx]);
				mul_b = 34'(tm_q[idx]);
			end
			cfmu_pkg::STEP_FMU: begin
				mul_a = 48'(ln_q);
				mul_b = 34'(mu_q);
			end
			[cfmu_pkg::STEP_SCALE:cfmu_pkg::STEP_SCALE+5'd2]: begin
				mul_a = 48'(fmax_q);
				mul_b = 34'(mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cfmu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign sqrt_in.start = sqrt_go_q;
	assign sqrt_in.done  = 1'b0;
	assign div_in.start  = div_go_q;
	assign div_in.done   = 1'b0;

	cfmu_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (sqrt_in),
		.ctl_out (sqrt_out),
		.x       (sq_q),
		.root    (root)
	);

	cfmu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (div_in),
		.ctl_out  (div_out),
		.dividend (mul_p[63:0]),
		.divisor  (root),
		.quotient (quo)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			cp_q[0] <= '0;
			cp_q[1] <= '0;
			cp_q[2] <= '0;
			n_q[0]  <= '0;
			n_q[1]  <= 18'sd65536;
			n_q[2]  <= '0;
			mu_q    <= '0;
		end else if (cfg_we) begin
			case (cfmu_pkg::reg_idx_t'(cfg_index))
				cfmu_pkg::REG_OWNER:    owner_q <= cfg_wdata[9:0];
				cfmu_pkg::REG_CONTACTX: cp_q[0] <= cfg_wdata;
				cfmu_pkg::REG_CONTACTY: cp_q[1] <= cfg_wdata;
				cfmu_pkg::REG_CONTACTZ: cp_q[2] <= cfg_wdata;
				cfmu_pkg::REG_NORMALX:  n_q[0]  <= cfg_wdata[17:0];
				cfmu_pkg::REG_NORMALY:  n_q[1]  <= cfg_wdata[17:0];
				cfmu_pkg::REG_NORMALZ:  n_q[2]  <= cfg_wdata[17:0];
				cfmu_pkg::REG_FRICTION: mu_q    <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// sequencer and multiplier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cfmu_pkg::ST_IDLE;
			pc_q      <= '0;
			mul_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			ln_q      <= '0;
			tm_q[0]   <= '0;
			tm_q[1]   <= '0;
			tm_q[2]   <= '0;
			out_v_q   <= 1'b0;
		end else begin
			mul_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			case (state_q)
				cfmu_pkg::ST_IDLE: begin
					if (take) begin
						pc_q <= cfmu_pkg::STEP_SEP;
						if (pres_in) begin
							mul_go_q <= 1'b1;
							state_q  <= cfmu_pkg::ST_MUL;
						end else begin
							state_q <= cfmu_pkg::ST_FIN;
						end
					end
				end
				cfmu_pkg::ST_MUL: begin
					if (mul_done) begin
						case (pc_q) inside
							cfmu_pkg::STEP_RHOC: begin
								if (kind_q == cfmu_pkg::KIND_UPDATE)
									ln_q <= cfmu_pkg::sat31u(66'(ln_s) + ps);
							end
							[cfmu_pkg::STEP_GRAD:cfmu_pkg::STEP_GRAD+5'd2]: begin
								if (kind_q == cfmu_pkg::KIND_UPDATE)
									tm_q[idx] <= cfmu_pkg::sat32(66'(tm_q[idx]) + ps);
							end
							default: ;
						endcase
						if (pc_q == cfmu_pkg::STEP_TAN + 5'd2 && kind_q == cfmu_pkg::KIND_GRAD
						    && !(vidx_q == owner_q && active_q)) begin
							state_q <= cfmu_pkg::ST_FIN;
						end else if (pc_q == cfmu_pkg::STEP_GRAD + 5'd2
						             && kind_q == cfmu_pkg::KIND_GRAD) begin
							state_q <= cfmu_pkg::ST_FIN;
						end else if (pc_q == cfmu_pkg::STEP_FMU) begin
							sqrt_go_q <= 1'b1;
							state_q   <= cfmu_pkg::ST_SQRT;
						end else if (pc_q >= cfmu_pkg::STEP_SCALE) begin
							div_go_q <= 1'b1;
							state_q  <= cfmu_pkg::ST_DIV;
						end else begin
							pc_q     <= pc_q + 1'b1;
							mul_go_q <= 1'b1;
						end
					end
				end
				cfmu_pkg::ST_SQRT: begin
					if (sqrt_out.done) begin
						if (cfmu_pkg::FMAX_W'(root) > fmax_q) begin
							pc_q     <= cfmu_pkg::STEP_SCALE;
							mul_go_q <= 1'b1;
							state_q  <= cfmu_pkg::ST_MUL;
						end else begin
							state_q <= cfmu_pkg::ST_FIN;
						end
					end
				end
				cfmu_pkg::ST_DIV: begin
					if (div_out.done) begin
						tm_q[idx] <= (tm_q[idx] < 0) ? -32'(quo) : 32'(quo);
						if (pc_q == cfmu_pkg::STEP_SCALE + 5'd2) begin
							state_q <= cfmu_pkg::ST_FIN;
						end else begin
							pc_q     <= pc_q + 1'b1;
							mul_go_q <= 1'b1;
							state_q  <= cfmu_pkg::ST_MUL;
						end
					end
				end
				cfmu_pkg::ST_FIN: begin
					if (ln_q == '0) begin
						tm_q[0] <= '0;
						tm_q[1] <= '0;
						tm_q[2] <= '0;
					end
					state_q <= cfmu_pkg::ST_OUT;
				end
				cfmu_pkg::ST_OUT: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						state_q <= cfmu_pkg::ST_IDLE;
					end
				end
				default: state_q <= cfmu_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q    <= s_tuser;
			vidx_q    <= s_tdata[9:0];
			pres_q    <= pres_in;
			pos_q[0]  <= s_tdata[42:11];
			pos_q[1]  <= s_tdata[74:43];
			pos_q[2]  <= s_tdata[106:75];
			vel_q[0]  <= s_tdata[138:107];
			vel_q[1]  <= s_tdata[170:139];
			vel_q[2]  <= s_tdata[202:171];
			rho_q     <= s_tdata[233:203];
			dt_q      <= s_tdata[245:234];
			acc_q     <= '0;
			sq_q      <= '0;
			grad_q[0] <= '0;
			grad_q[1] <= '0;
			grad_q[2] <= '0;
			diag_en_q <= 1'b0;
		end else if (state_q == cfmu_pkg::ST_MUL && mul_done) begin
			case (pc_q) inside
				[cfmu_pkg::STEP_SEP:cfmu_pkg::STEP_SEP+5'd2],
				[cfmu_pkg::STEP_VN:cfmu_pkg::STEP_VN+5'd2]: begin
					acc_q <= acc_nx;
					if (pc_q == cfmu_pkg::STEP_SEP + 5'd2) begin
						acc_q    <= '0;
						c_q      <= c_nx;
						active_q <= (c_nx < 0) || (ln_q != '0);
						pen_q    <= cfmu_pkg::sat31u(-66'(c_nx));
					end
					if (pc_q == cfmu_pkg::STEP_VN + 5'd2)
						vn_q <= c_nx;
				end
				[cfmu_pkg::STEP_TAN:cfmu_pkg::STEP_TAN+5'd2]: begin
					t_q[idx] <= cfmu_pkg::sat32(66'(vel_q[idx]) - ps);
					if (pc_q == cfmu_pkg::STEP_TAN + 5'd2)
						diag_en_q <= (kind_q == cfmu_pkg::KIND_GRAD) && (vidx_q == owner_q)
						             && active_q;
				end
				cfmu_pkg::STEP_RHOC: begin
					psi_q <= cfmu_pkg::sat32(66'(ln_s) + ps);
				end
				[cfmu_pkg::STEP_RT:cfmu_pkg::STEP_RT+5'd2]: begin
					if (kind_q == cfmu_pkg::KIND_GRAD)
						t_q[idx] <= cfmu_pkg::sat32(66'(tm_q[idx]) + ps);
					else
						t_q[idx] <= cfmu_pkg::sat32(ps);
				end
				[cfmu_pkg::STEP_GRAD:cfmu_pkg::STEP_GRAD+5'd2]: begin
					if (kind_q == cfmu_pkg::KIND_GRAD)
						grad_q[idx] <= cfmu_pkg::sat32(ps + 66'(t_q[idx]));
				end
				[cfmu_pkg::STEP_SQ:cfmu_pkg::STEP_SQ+5'd2]: begin
					sq_q <= sq_q + mul_p[63:0];
				end
				cfmu_pkg::STEP_FMU: begin
					fmax_q <= ps[cfmu_pkg::FMAX_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == cfmu_pkg::ST_OUT && (!out_v_q || m_tready)) begin
			out_q <= {2'b00,
			          pres_q ? pen_q : 31'd0,
			          tm_q[2], tm_q[1], tm_q[0],
			          ln_q,
			          pres_q && active_q,
			          diag_en_q ? diag : 31'd0,
			          grad_q[2], grad_q[1], grad_q[0]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

// ===== rtl/core/cfmu_chk.sv =====
// ----------------------------------------------------------------------------
// cfmu_chk
// Port-level checks of the contact unit, bound to the top level.
// ----------------------------------------------------------------------------
module cfmu_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [cfmu_pkg::IN_W-1:0]           s_tdata,
	input logic                                s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [cfmu_pkg::OUT_W-1:0]          m_tdata,
	input logic                                cfg_we,
	input logic [cfmu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [cfmu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while one in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_diag_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[126:96] != 31'd0 |-> m_tdata[127])
		else $error("diagonal term on inactive contact");

	a_pen_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[285:255] != 31'd0 |-> m_tdata[127])
		else $error("penetration without activity");

	a_tangent_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[158:128] == 31'd0 |-> m_tdata[254:159] == 96'd0)
		else $error("tangent multiplier kept with zero normal multiplier");

endmodule

bind contact_friction_multiplier_unit cfmu_chk u_cfmu_chk (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Contact unit check: query words with random gaps drive the unit while an
// in-bench model of the contact and its multipliers predicts every result
// word, compared field by field as results are taken under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct packed {
		logic [1:0]         pad;
		logic [11:0]        dt;
		logic [30:0]        rho;
		logic signed [31:0] vel_z;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
		logic               present;
		logic [9:0]         vidx;
	} query_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic [30:0]        pen;
		logic signed [31:0] tmult_z;
		logic signed [31:0] tmult_y;
		logic signed [31:0] tmult_x;
		logic [30:0]        nmult;
		logic               active;
		logic [30:0]        diag;
		logic signed [31:0] grad_z;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_x;
	} contact_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [cfmu_pkg::IN_W-1:0]       s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [cfmu_pkg::OUT_W-1:0]      m_tdata;
	logic                            cfg_we;
	logic [cfmu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cfmu_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// shadow registers and multipliers
	longint   sh_owner;
	longint   sh_cp [3];
	longint   sh_n [3];
	longint   sh_mu;
	longint   lam_n;
	longint   lam_t [3];

	contact_t contact_q [$];
	int       mismatches;
	int       idle_cycles;
	bit       quiet;

	contact_friction_multiplier_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint clip31u(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < 0)
			return 0;
		return x;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag64(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// response of the contact to one query word; updates the multipliers
	function automatic contact_t contact_response(logic kind, query_t q);
		contact_t    r;
		longint      pos [3];
		longint      vel [3];
		longint      t [3];
		longint      g [3];
		longint      acc, accv, c, vn, rho, rt, dt, psi_n, psi_t, stepv, fmax, pen;
		logic [63:0] sq, m, qq;
		bit          present, act;
		int          i;
		r = '0;
		pos[0] = longint'(q.pos_x); pos[1] = longint'(q.pos_y); pos[2] = longint'(q.pos_z);
		vel[0] = longint'(q.vel_x); vel[1] = longint'(q.vel_y); vel[2] = longint'(q.vel_z);
		rho = longint'(q.rho);
		dt = longint'(q.dt);
		rt = rho >>> 2;
		g[0] = 0; g[1] = 0; g[2] = 0;
		c = 0; pen = 0; act = 0;
		present = q.present && (sh_owner < cfmu_pkg::MAX_VERTICES);
		if (present) begin
			acc = 0;
			accv = 0;
			for (i = 0; i < 3; i++) begin
				acc += sh_n[i] * (pos[i] - sh_cp[i]);
				accv += vel[i] * sh_n[i];
			end
			c = clip32(acc >>> cfmu_pkg::FRAC_BITS);
			vn = clip32(accv >>> cfmu_pkg::FRAC_BITS);
			for (i = 0; i < 3; i++)
				t[i] = clip32(vel[i] - ((sh_n[i] * vn) >>> cfmu_pkg::FRAC_BITS));
			act = (c < 0) || (lam_n > 0);
			pen = clip31u(-c);
			if (kind == cfmu_pkg::KIND_GRAD && longint'(q.vidx) == sh_owner && act) begin
				psi_n = clip32(lam_n + ((rho * c) >>> cfmu_pkg::FRAC_BITS));
				for (i = 0; i < 3; i++) begin
					psi_t = clip32(lam_t[i] + ((rt * t[i]) >>> cfmu_pkg::FRAC_BITS));
					g[i] = clip32(((psi_n * sh_n[i]) >>> cfmu_pkg::FRAC_BITS) + psi_t);
				end
				r.diag = 31'(clip31u(rho + 3 * rt));
			end
			if (kind == cfmu_pkg::KIND_UPDATE) begin
				lam_n = clip31u(lam_n + ((rho * c) >>> cfmu_pkg::FRAC_BITS));
				sq = 0;
				for (i = 0; i < 3; i++) begin
					stepv = clip32((rt * t[i]) >>> cfmu_pkg::FRAC_BITS);
					lam_t[i] = clip32(lam_t[i] + ((stepv * dt) >>> cfmu_pkg::FRAC_BITS));
					sq += mag64(lam_t[i]) * mag64(lam_t[i]);
				end
				m = root64(sq);
				fmax = (sh_mu * lam_n) >>> cfmu_pkg::FRAC_BITS;
				if (m > 64'(fmax) && m != 0) begin
					for (i = 0; i < 3; i++) begin
						qq = mag64(lam_t[i]) * 64'(fmax) / m;
						lam_t[i] = (lam_t[i] < 0) ? -longint'(qq) : longint'(qq);
					end
				end
				if (lam_n == 0)
					for (i = 0; i < 3; i++)
						lam_t[i] = 0;
			end
		end
		r.grad_x = 32'(g[0]);
		r.grad_y = 32'(g[1]);
		r.grad_z = 32'(g[2]);
		r.active = act;
		r.nmult = 31'(lam_n);
		r.tmult_x = 32'(lam_t[0]);
		r.tmult_y = 32'(lam_t[1]);
		r.tmult_z = 32'(lam_t[2]);
		r.pen = 31'(pen);
		return r;
	endfunction

	task automatic write_reg(cfmu_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			cfmu_pkg::REG_OWNER:    sh_owner = longint'(val[9:0]);
			cfmu_pkg::REG_CONTACTX: sh_cp[0] = longint'($signed(val));
			cfmu_pkg::REG_CONTACTY: sh_cp[1] = longint'($signed(val));
			cfmu_pkg::REG_CONTACTZ: sh_cp[2] = longint'($signed(val));
			cfmu_pkg::REG_NORMALX:  sh_n[0] = longint'($signed(val[17:0]));
			cfmu_pkg::REG_NORMALY:  sh_n[1] = longint'($signed(val[17:0]));
			cfmu_pkg::REG_NORMALZ:  sh_n[2] = longint'($signed(val[17:0]));
			cfmu_pkg::REG_FRICTION: sh_mu = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_contact(int owner, int cx, int cy, int cz, int nx, int ny, int nz,
			int mu);
		write_reg(cfmu_pkg::REG_OWNER, owner);
		write_reg(cfmu_pkg::REG_CONTACTX, cx);
		write_reg(cfmu_pkg::REG_CONTACTY, cy);
		write_reg(cfmu_pkg::REG_CONTACTZ, cz);
		write_reg(cfmu_pkg::REG_NORMALX, nx);
		write_reg(cfmu_pkg::REG_NORMALY, ny);
		write_reg(cfmu_pkg::REG_NORMALZ, nz);
		write_reg(cfmu_pkg::REG_FRICTION, mu);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(logic kind, query_t q);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= q;
		do @(posedge clk); while (!s_tready);
		contact_q.insert(contact_q.size(), contact_response(kind, q));
	endtask

	// wait for every result, then let the unit settle before registers move
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (contact_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic query_t make_query(int vidx, bit present, int dx, int dy, int dz,
			int vx, int vy, int vz, int rho, int dt);
		query_t q;
		q = '0;
		q.vidx = 10'(vidx);
		q.present = present;
		q.pos_x = 32'(sh_cp[0] + dx);
		q.pos_y = 32'(sh_cp[1] + dy);
		q.pos_z = 32'(sh_cp[2] + dz);
		q.vel_x = vx;
		q.vel_y = vy;
		q.vel_z = vz;
		q.rho = 31'(rho);
		q.dt = 12'(dt);
		return q;
	endfunction

	function automatic int spread(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic query_t random_query();
		query_t q;
		int     sel;
		sel = $urandom_range(0, 99);
		if (sel < 85) begin
			q = make_query(($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023))
					: int'(sh_owner),
				$urandom_range(0, 15) != 0,
				spread(1 << 18), spread(1 << 18), spread(1 << 18),
				spread(1 << 20), spread(1 << 20), spread(1 << 20),
				$urandom_range(65536, 65536 << 8), $urandom_range(0, 3277));
		end else begin
			q.pad = '0;
			q.vidx = 10'($urandom_range(0, 1023));
			q.present = 1'($urandom_range(0, 1));
			q.pos_x = $urandom; q.pos_y = $urandom; q.pos_z = $urandom;
			q.vel_x = $urandom; q.vel_y = $urandom; q.vel_z = $urandom;
			q.rho = 31'($urandom_range(65536, 32'h7fffffff));
			q.dt = 12'($urandom_range(0, 3277));
		end
		return q;
	endfunction

	task automatic test_reset_defaults();
		quiet = 1'b1;
		send_word(cfmu_pkg::KIND_GRAD, make_query(0, 1, 0, 0, 0, 0, 0, 0, 65536, 0));
		send_word(cfmu_pkg::KIND_GRAD, make_query(0, 1, 0, -65536, 0, 65536, 0, 0, 65536, 3277));
		send_word(cfmu_pkg::KIND_UPDATE,
			make_query(0, 1, 0, -65536, 0, 65536, 0, 0, 65536, 3277));
		drain();
		quiet = 1'b0;
	endtask

	task automatic test_directed();
		set_contact(1023, 32'h7fffffff, 32'h80000000, 0, -65536, 65536, 65536, 32'h7fffffff);
		// extreme field values, contact point x and y at the limits
		send_word(cfmu_pkg::KIND_GRAD, make_query(1023, 1, -1, 1, 0, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 3277));
		send_word(cfmu_pkg::KIND_UPDATE, make_query(1023, 1, 32'h80000000, 32'h7fffffff, -1,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 3277));
		send_word(cfmu_pkg::KIND_GRAD, make_query(0, 1, 0, 0, 0, 0, 0, 0, 65536, 0));
		send_word(cfmu_pkg::KIND_UPDATE, make_query(1023, 0, -4096, -4096, 0, 1000, 1000, 1000,
			65536, 3277));
		drain();
		set_contact(5, 0, 0, 0, 0, 65536, 0, 32768);
		// resting contact: active only while the normal multiplier is positive
		send_word(cfmu_pkg::KIND_GRAD, make_query(5, 1, 0, 0, 0, 0, 0, 0, 65536, 100));
		// penetration lowers the normal multiplier, sliding builds the tangent one
		send_word(cfmu_pkg::KIND_UPDATE,
			make_query(5, 1, 0, -8192, 0, 300000, 0, -200000, 262144, 3277));
		send_word(cfmu_pkg::KIND_UPDATE,
			make_query(5, 1, 0, -4096, 0, 900000, 5, 700000, 1 << 24, 3277));
		send_word(cfmu_pkg::KIND_GRAD,
			make_query(5, 1, 100, -4096, 0, 65536, 0, 0, 262144, 3277));
		// other vertex and absent vertex
		send_word(cfmu_pkg::KIND_GRAD, make_query(6, 1, 0, -4096, 0, 0, 0, 0, 262144, 3277));
		send_word(cfmu_pkg::KIND_GRAD, make_query(5, 0, 0, -4096, 0, 0, 0, 0, 262144, 3277));
		// separated but multiplier still positive: active
		send_word(cfmu_pkg::KIND_GRAD, make_query(5, 1, 0, 65536, 0, 0, 0, 0, 65536, 3277));
		// pulling away clamps the normal multiplier at its top
		send_word(cfmu_pkg::KIND_UPDATE,
			make_query(5, 1, 0, 1 << 24, 0, 65536, 0, 0, 32'h7fffffff, 0));
		send_word(cfmu_pkg::KIND_GRAD, make_query(5, 1, 0, 1 << 16, 0, 0, 0, 0, 65536, 0));
		drain();
	endtask

	task automatic test_random(int count);
		int i;
		int nsel;
		int n;
		int mu;
		for (i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				drain();
				quiet = ($urandom_range(0, 3) == 0);
				nsel = $urandom_range(0, 3);
				mu = ($urandom_range(0, 2) == 0) ? 0 :
					(($urandom_range(0, 3) == 0) ? 32'h7fffffff : $urandom_range(0, 2 << 16));
				n = ($urandom_range(0, 1) != 0) ? 65536 : -65536;
				case (nsel)
					0: set_contact($urandom_range(0, 1023), spread(1 << 24), spread(1 << 24),
						spread(1 << 24), n, 0, 0, mu);
					1: set_contact($urandom_range(0, 1023), spread(1 << 24), spread(1 << 24),
						spread(1 << 24), 0, n, 0, mu);
					2: set_contact($urandom_range(0, 1023), spread(1 << 24), spread(1 << 24),
						spread(1 << 24), 0, 0, n, mu);
					default: set_contact($urandom_range(0, 1023), spread(1 << 24),
						spread(1 << 24), spread(1 << 24), spread(46341), spread(46341),
						spread(46341), mu);
				endcase
			end
			send_word(1'($urandom_range(0, 1)), random_query());
		end
		drain();
	endtask

	task automatic check_field(string fname, longint want, longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d, got %0d", fname, want, got);
		end
	endtask

	// result side: stall per word, then take it
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			n = quiet ? 0 : $urandom_range(0, 10);
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		contact_t got, want;
		if (m_tvalid && m_tready) begin
			got = contact_t'(m_tdata);
			if (contact_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with no query outstanding");
			end else begin
				want = contact_q.pop_front();
				check_field("grad_x", want.grad_x, got.grad_x);
				check_field("grad_y", want.grad_y, got.grad_y);
				check_field("grad_z", want.grad_z, got.grad_z);
				check_field("diag_add", want.diag, got.diag);
				check_field("is_active", want.active, got.active);
				check_field("normal_mult", want.nmult, got.nmult);
				check_field("tangent_mult_x", want.tmult_x, got.tmult_x);
				check_field("tangent_mult_y", want.tmult_y, got.tmult_y);
				check_field("tangent_mult_z", want.tmult_z, got.tmult_z);
				check_field("penetration", want.pen, got.pen);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** contact_friction_multiplier_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = cfmu_pkg::KIND_GRAD;
		cfg_we = 1'b0;
		cfg_index = cfmu_pkg::REG_OWNER;
		cfg_wdata = '0;
		mismatches = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		sh_owner = 0;
		sh_cp[0] = 0; sh_cp[1] = 0; sh_cp[2] = 0;
		sh_n[0] = 0; sh_n[1] = 65536; sh_n[2] = 0;
		sh_mu = 0;
		lam_n = 0;
		lam_t[0] = 0; lam_t[1] = 0; lam_t[2] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed();
		test_random(730);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && contact_q.size() == 0)
			$display("** contact_friction_multiplier_unit: PASSED **");
		else
			$display("** contact_friction_multiplier_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/cfmu_pkg.sv
rtl/core/cfmu_mul.sv
rtl/core/cfmu_sqrt.sv
rtl/core/cfmu_div.sv
rtl/core/contact_friction_multiplier_unit.sv
rtl/core/cfmu_chk.sv
tb/testbench.sv
